[rtl/core/array_doubly_linked_list_engine_core_macros.svh]
// Assertion macros for the list engine RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ARRAY_DOUBLY_LINKED_LIST_ENGINE_CORE_MACROS_SVH
`define ARRAY_DOUBLY_LINKED_LIST_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define ADLL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ADLL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/adll_pkg.sv]
// Package for the array-based doubly linked list engine.
// Sizes, slot/opcode/status types, allocator structs and name clean-up; no dependencies.
`timescale 1ns / 1ps

package adll_pkg;

  localparam int SLOTS          = 16;
  localparam int NAME_BYTES_DEF = 8;
  localparam int IDX_W          = $clog2(SLOTS);
  localparam int SLOT_W         = 5;
  localparam int PLACE_W        = 64;
  localparam int WEIGHT_W       = 32;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam slot_t SLOT_NONE = slot_t'(SLOTS);

  typedef enum logic [2:0] {
    OP_ADD_HEAD  = 3'd0,
    OP_ADD_AFTER = 3'd1,
    OP_ADD_TAIL  = 3'd2,
    OP_DEL_HEAD  = 3'd3,
    OP_DEL_AFTER = 3'd4,
    OP_DEL_TAIL  = 3'd5,
    OP_CLEAR     = 3'd6,
    OP_READ      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_BADPOS = 3'd3,
    ST_NOSUCC = 3'd4
  } status_t;

  typedef struct packed {
    logic set;
    logic clr;
    logic clr_all;
    idx_t idx;
  } alloc_cmd_t;

  typedef struct packed {
    logic [SLOTS-1:0] in_use;
    slot_t            free_slot;
  } alloc_stat_t;

  // keep at most nb bytes, and nothing from the first zero byte on
  function automatic logic [PLACE_W-1:0] clean_name(input logic [PLACE_W-1:0] p,
                                                    input int nb);
    logic [PLACE_W-1:0] r;
    logic               live;
    r    = '0;
    live = 1'b1;
    for (int i = 0; i < PLACE_W / 8; i++) begin
      if (p[8*i +: 8] == 8'h00 || i >= nb) begin
        live = 1'b0;
      end
      if (live) begin
        r[8*i +: 8] = p[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

[rtl/core/adll_ram.sv]
// Generic single-write, single-read synchronous RAM with bit write mask.
// Registered read; no dependencies.
`timescale 1ns / 1ps

module adll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [WIDTH-1:0]         wr_mask,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < WIDTH; i++) begin
        if (wr_mask[i]) begin
          mem[wr_addr][i] <= wr_data[i];
        end
      end
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/adll_alloc.sv]
// Slot allocator: in-use flags and lowest-free-slot finder.
// Depends on adll_pkg.
`timescale 1ns / 1ps

module adll_alloc (
  input  logic                  clk,
  input  logic                  rst_n,
  input  adll_pkg::alloc_cmd_t  cmd,
  output adll_pkg::alloc_stat_t stat
);

  localparam int N = adll_pkg::SLOTS;

  logic [N-1:0]   in_use_r;
  logic [N-1:0]   in_use_nxt;
  logic [N-1:0]   free_vec;
  logic [N-1:0]   low_bit;
  adll_pkg::idx_t low_idx;

  always_comb begin
    in_use_nxt = in_use_r;
    if (cmd.clr_all) begin
      in_use_nxt = '0;
    end else begin
      if (cmd.set) begin
        in_use_nxt[cmd.idx] = 1'b1;
      end
      if (cmd.clr) begin
        in_use_nxt[cmd.idx] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else begin
      in_use_r <= in_use_nxt;
    end
  end

  // isolate lowest free bit, then encode
  always_comb begin
    free_vec = ~in_use_r;
    low_bit  = free_vec & (~free_vec + {{(N-1){1'b0}}, 1'b1});
    low_idx  = '0;
    for (int i = 0; i < N; i++) begin
      low_idx = low_idx | (low_bit[i] ? adll_pkg::idx_t'(i) : '0);
    end
  end

  assign stat.in_use    = in_use_r;
  assign stat.free_slot = (|free_vec) ? adll_pkg::slot_t'(low_idx) : adll_pkg::SLOT_NONE;

endmodule

[rtl/core/array_doubly_linked_list_engine_core.sv]
// Top level of the array-based doubly linked list engine.
// Depends on adll_pkg, adll_ram, adll_alloc and the assertion macro header.
//
//   channel | ports          | beat
//   --------+----------------+-----------------------------------------------
//   in      | in_valid/stall | operation, position, place, weight
//   out     | out_valid/stall| status, slot, payload, links, count, head, tail
//
// One request at a time; clear and errors found at accept go to S_DONE, others
// step through S_RDA (add/delete after), S_RDB (read, delete), S_W1 (add) and
// S_W2, S_W3 (add, delete) in that order; no successor ends after S_RDA.
// The single write port of the link RAM takes one link entry a cycle.
// Reset: synchronous, active low; list empty, no clearing pass.
// A held result stalls only the final step; the output register parts the sides.
`timescale 1ns / 1ps
`include "array_doubly_linked_list_engine_core_macros.svh"

module array_doubly_linked_list_engine_core #(
  parameter int NAME_BYTES = adll_pkg::NAME_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic [3:0]         in_position,
  input  logic [63:0]        in_place,
  input  logic signed [31:0] in_weight,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [4:0]         out_slot,
  output logic [63:0]        out_entry_place,
  output logic signed [31:0] out_entry_weight,
  output logic [4:0]         out_prev_slot,
  output logic [4:0]         out_next_slot,
  output logic [4:0]         out_entry_count,
  output logic [4:0]         out_head_slot,
  output logic [4:0]         out_tail_slot
);

  localparam int SLOT_W = adll_pkg::SLOT_W;
  localparam int IDX_W  = adll_pkg::IDX_W;
  localparam int NAME_W = NAME_BYTES * 8;
  localparam int LINK_W = 2 * SLOT_W;
  localparam int PAY_W  = NAME_W + adll_pkg::WEIGHT_W;

  localparam logic [LINK_W-1:0] MASK_ALL  = '1;
  localparam logic [LINK_W-1:0] MASK_PREV = {{SLOT_W{1'b1}}, {SLOT_W{1'b0}}};
  localparam logic [LINK_W-1:0] MASK_NEXT = {{SLOT_W{1'b0}}, {SLOT_W{1'b1}}};

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RDA  = 7'b0000010,
    S_RDB  = 7'b0000100,
    S_W1   = 7'b0001000,
    S_W2   = 7'b0010000,
    S_W3   = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  adll_pkg::op_t           op_r, op_nxt;
  adll_pkg::idx_t          pos_r, pos_nxt;
  logic [NAME_W-1:0]       place_r, place_nxt;
  logic signed [31:0]      weight_r, weight_nxt;
  adll_pkg::slot_t         s_r, s_nxt;
  adll_pkg::slot_t         p_r, p_nxt;
  adll_pkg::slot_t         n_r, n_nxt;
  adll_pkg::status_t       st_r, st_nxt;
  adll_pkg::slot_t         head_r, head_nxt;
  adll_pkg::slot_t         tail_r, tail_nxt;
  adll_pkg::slot_t         count_r, count_nxt;

  logic                    out_valid_r, out_valid_nxt;
  adll_pkg::status_t       out_status_r, out_status_nxt;
  adll_pkg::slot_t         out_slot_r, out_slot_nxt;
  logic [63:0]             out_place_r, out_place_nxt;
  logic signed [31:0]      out_weight_r, out_weight_nxt;
  adll_pkg::slot_t         out_prev_r, out_prev_nxt;
  adll_pkg::slot_t         out_next_r, out_next_nxt;
  adll_pkg::slot_t         out_count_r, out_count_nxt;
  adll_pkg::slot_t         out_head_r, out_head_nxt;
  adll_pkg::slot_t         out_tail_r, out_tail_nxt;

  adll_pkg::alloc_cmd_t    alloc_cmd;
  adll_pkg::alloc_stat_t   alloc_stat;

  logic                    lk_wr_en;
  adll_pkg::idx_t          lk_wr_addr;
  logic [LINK_W-1:0]       lk_wr_data;
  logic [LINK_W-1:0]       lk_wr_mask;
  logic                    lk_rd_en;
  logic [LINK_W-1:0]       lk_rd_data;
  logic                    py_wr_en;
  logic                    py_rd_en;
  logic [PAY_W-1:0]        py_rd_data;
  adll_pkg::idx_t          rd_addr;

  logic                    pos_ok;
  logic                    full;
  logic                    is_ins;
  adll_pkg::slot_t         rd_prev;
  adll_pkg::slot_t         rd_next;

  assign in_stall = (state_r != S_IDLE);
  assign pos_ok   = alloc_stat.in_use[in_position];
  assign full     = (count_r == adll_pkg::SLOT_NONE);
  assign is_ins   = (op_r == adll_pkg::OP_ADD_HEAD) || (op_r == adll_pkg::OP_ADD_AFTER) ||
                    (op_r == adll_pkg::OP_ADD_TAIL);
  assign rd_prev  = lk_rd_data[LINK_W-1:SLOT_W];
  assign rd_next  = lk_rd_data[SLOT_W-1:0];

  adll_alloc u_alloc (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (alloc_cmd),
    .stat  (alloc_stat)
  );

  // {prev, next} per slot
  adll_ram #(
    .WIDTH (LINK_W),
    .DEPTH (adll_pkg::SLOTS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (lk_wr_en),
    .wr_addr (lk_wr_addr),
    .wr_data (lk_wr_data),
    .wr_mask (lk_wr_mask),
    .rd_en   (lk_rd_en),
    .rd_addr (rd_addr),
    .rd_data (lk_rd_data)
  );

  // {place, weight} per slot
  adll_ram #(
    .WIDTH (PAY_W),
    .DEPTH (adll_pkg::SLOTS)
  ) u_pay_ram (
    .clk     (clk),
    .wr_en   (py_wr_en),
    .wr_addr (s_r[IDX_W-1:0]),
    .wr_data ({place_r, weight_r}),
    .wr_mask ({PAY_W{1'b1}}),
    .rd_en   (py_rd_en),
    .rd_addr (rd_addr),
    .rd_data (py_rd_data)
  );

  // reads of a request always precede its writes, and requests do not overlap,
  // so no forwarding is needed
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    place_nxt      = place_r;
    weight_nxt     = weight_r;
    s_nxt          = s_r;
    p_nxt          = p_r;
    n_nxt          = n_r;
    st_nxt         = st_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_place_nxt  = out_place_r;
    out_weight_nxt = out_weight_r;
    out_prev_nxt   = out_prev_r;
    out_next_nxt   = out_next_r;
    out_count_nxt  = out_count_r;
    out_head_nxt   = out_head_r;
    out_tail_nxt   = out_tail_r;
    alloc_cmd      = '0;
    lk_wr_en       = 1'b0;
    lk_wr_addr     = '0;
    lk_wr_data     = '0;
    lk_wr_mask     = '0;
    lk_rd_en       = 1'b0;
    py_wr_en       = 1'b0;
    py_rd_en       = 1'b0;
    rd_addr        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = adll_pkg::op_t'(in_operation);
          pos_nxt    = in_position;
          place_nxt  = NAME_W'(adll_pkg::clean_name(in_place, NAME_BYTES));
          weight_nxt = in_weight;
          s_nxt      = adll_pkg::SLOT_NONE;
          p_nxt      = adll_pkg::SLOT_NONE;
          n_nxt      = adll_pkg::SLOT_NONE;
          st_nxt     = adll_pkg::ST_OK;
          state_nxt  = S_DONE;
          unique case (adll_pkg::op_t'(in_operation))
            adll_pkg::OP_ADD_HEAD: begin
              if (full) begin
                st_nxt = adll_pkg::ST_FULL;
              end else begin
                s_nxt     = alloc_stat.free_slot;
                n_nxt     = head_r;
                state_nxt = S_W1;
              end
            end
            adll_pkg::OP_ADD_TAIL: begin
              if (full) begin
                st_nxt = adll_pkg::ST_FULL;
              end else begin
                s_nxt     = alloc_stat.free_slot;
                p_nxt     = tail_r;
                state_nxt = S_W1;
              end
            end
            adll_pkg::OP_ADD_AFTER: begin
              if (!pos_ok) begin
                st_nxt = adll_pkg::ST_BADPOS;
              end else if (full) begin
                st_nxt = adll_pkg::ST_FULL;
              end else begin
                lk_rd_en  = 1'b1;
                rd_addr   = in_position;
                state_nxt = S_RDA;
              end
            end
            adll_pkg::OP_DEL_HEAD, adll_pkg::OP_DEL_TAIL: begin
              if (count_r == '0) begin
                st_nxt = adll_pkg::ST_EMPTY;
              end else begin
                s_nxt = (adll_pkg::op_t'(in_operation) == adll_pkg::OP_DEL_HEAD) ?
                        head_r : tail_r;
                lk_rd_en  = 1'b1;
                py_rd_en  = 1'b1;
                rd_addr   = s_nxt[IDX_W-1:0];
                state_nxt = S_RDB;
              end
            end
            adll_pkg::OP_DEL_AFTER: begin
              if (!pos_ok) begin
                st_nxt = adll_pkg::ST_BADPOS;
              end else begin
                lk_rd_en  = 1'b1;
                rd_addr   = in_position;
                state_nxt = S_RDA;
              end
            end
            adll_pkg::OP_CLEAR: begin
              alloc_cmd.clr_all = 1'b1;
              head_nxt          = adll_pkg::SLOT_NONE;
              tail_nxt          = adll_pkg::SLOT_NONE;
              count_nxt         = '0;
            end
            adll_pkg::OP_READ: begin
              if (!pos_ok) begin
                st_nxt = adll_pkg::ST_BADPOS;
              end else begin
                s_nxt     = adll_pkg::slot_t'(in_position);
                lk_rd_en  = 1'b1;
                py_rd_en  = 1'b1;
                rd_addr   = in_position;
                state_nxt = S_RDB;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_RDA: begin
        if (op_r == adll_pkg::OP_ADD_AFTER) begin
          s_nxt     = alloc_stat.free_slot;
          p_nxt     = adll_pkg::slot_t'(pos_r);
          n_nxt     = rd_next;
          state_nxt = S_W1;
        end else if (rd_next == adll_pkg::SLOT_NONE) begin
          st_nxt    = adll_pkg::ST_NOSUCC;
          state_nxt = S_DONE;
        end else begin
          s_nxt     = rd_next;
          lk_rd_en  = 1'b1;
          py_rd_en  = 1'b1;
          rd_addr   = rd_next[IDX_W-1:0];
          state_nxt = S_RDB;
        end
      end

      S_RDB: begin
        p_nxt      = rd_prev;
        n_nxt      = rd_next;
        place_nxt  = py_rd_data[PAY_W-1:32];
        weight_nxt = $signed(py_rd_data[31:0]);
        state_nxt  = (op_r == adll_pkg::OP_READ) ? S_DONE : S_W2;
      end

      S_W1: begin
        lk_wr_en   = 1'b1;
        lk_wr_addr = s_r[IDX_W-1:0];
        lk_wr_data = {p_r, n_r};
        lk_wr_mask = MASK_ALL;
        py_wr_en   = 1'b1;
        state_nxt  = S_W2;
      end

      S_W2: begin
        lk_wr_en   = (p_r != adll_pkg::SLOT_NONE);
        lk_wr_addr = p_r[IDX_W-1:0];
        lk_wr_data = {{SLOT_W{1'b0}}, (is_ins ? s_r : n_r)};
        lk_wr_mask = MASK_NEXT;
        state_nxt  = S_W3;
      end

      S_W3: begin
        lk_wr_en      = (n_r != adll_pkg::SLOT_NONE);
        lk_wr_addr    = n_r[IDX_W-1:0];
        lk_wr_data    = {(is_ins ? s_r : p_r), {SLOT_W{1'b0}}};
        lk_wr_mask    = MASK_PREV;
        alloc_cmd.idx = s_r[IDX_W-1:0];
        if (is_ins) begin
          alloc_cmd.set = 1'b1;
          count_nxt     = count_r + SLOT_W'(1);
          if (p_r == adll_pkg::SLOT_NONE) begin
            head_nxt = s_r;
          end
          if (n_r == adll_pkg::SLOT_NONE) begin
            tail_nxt = s_r;
          end
        end else begin
          alloc_cmd.clr = 1'b1;
          count_nxt     = count_r - SLOT_W'(1);
          if (p_r == adll_pkg::SLOT_NONE) begin
            head_nxt = n_r;
          end
          if (n_r == adll_pkg::SLOT_NONE) begin
            tail_nxt = p_r;
          end
        end
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_slot_nxt   = s_r;
          out_prev_nxt   = p_r;
          out_next_nxt   = n_r;
          out_count_nxt  = count_r;
          out_head_nxt   = head_r;
          out_tail_nxt   = tail_r;
          if (st_r == adll_pkg::ST_OK && s_r != adll_pkg::SLOT_NONE) begin
            out_place_nxt  = 64'(place_r);
            out_weight_nxt = weight_r;
          end else begin
            out_place_nxt  = '0;
            out_weight_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= adll_pkg::SLOT_NONE;
      tail_r      <= adll_pkg::SLOT_NONE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    place_r      <= place_nxt;
    weight_r     <= weight_nxt;
    s_r          <= s_nxt;
    p_r          <= p_nxt;
    n_r          <= n_nxt;
    st_r         <= st_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_place_r  <= out_place_nxt;
    out_weight_r <= out_weight_nxt;
    out_prev_r   <= out_prev_nxt;
    out_next_r   <= out_next_nxt;
    out_count_r  <= out_count_nxt;
    out_head_r   <= out_head_nxt;
    out_tail_r   <= out_tail_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_slot         = out_slot_r;
  assign out_entry_place  = out_place_r;
  assign out_entry_weight = out_weight_r;
  assign out_prev_slot    = out_prev_r;
  assign out_next_slot    = out_next_r;
  assign out_entry_count  = out_count_r;
  assign out_head_slot    = out_head_r;
  assign out_tail_slot    = out_tail_r;

  `ADLL_ASSERT_IMP(a_count_matches_flags, 1'b1, $countones(alloc_stat.in_use) == count_r, "count out of step with in-use flags")
  `ADLL_ASSERT_IMP(a_head_empty, 1'b1, (head_r == adll_pkg::SLOT_NONE) == (count_r == '0), "head and count disagree on empty")
  `ADLL_ASSERT_IMP(a_tail_empty, 1'b1, (tail_r == adll_pkg::SLOT_NONE) == (count_r == '0), "tail and count disagree on empty")
  `ADLL_ASSERT_NXT(a_done_holds, state_r == S_DONE && out_valid_r && out_stall, state_r == S_DONE, "result step left while output held")

endmodule
